// File: sv/lpht_pkg.sv
package lpht_pkg;

  localparam int KEY_W  = 31;
  localparam int SIZE_W = 7;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;
  localparam int ENT_W  = KEY_W + 1;
  localparam int DIV_CNT_W = $clog2(KEY_W);

  typedef logic [STAT_W-1:0] status_t;
  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_FULL = 2'd1;
  localparam status_t ST_MISS = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam size_t SIZE_RESET = 7'd64;

endpackage

// File: sv/linear_probe_hash_table_core.sv
// Open-addressing hash table with linear probing over a synchronous memory
// (one write and one read port) of TABLE_DEPTH entries (valid bit plus key).
// After reset the block clears every entry and accepts no item until that
// pass ends; cfg writes are taken at any time. An item passes through a
// bit-serial remainder of the 31-bit key by the table size and then P probes
// (1 to size), each probe a memory read state followed by a check state,
// before its result is registered. An insert into a table whose entry count
// has reached the size skips probing. One item is worked on at a time; the
// next is taken while a result still waits in the output register.
module linear_probe_hash_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [6:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  lpht_pkg::key_t       in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lpht_pkg::status_t    out_status,
  output lpht_pkg::slot_t      out_slot
);
  import lpht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_RES
  } state_t;

  state_t                 state_r;
  size_t                  tsize_r;
  size_t                  entry_cnt_r;
  logic [AW-1:0]          clr_cnt_r;
  logic                   cmd_r;
  key_t                   key_r;
  key_t                   div_q_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  size_t                  rem_r;
  size_t                  addr_r;
  size_t                  probe_cnt_r;
  status_t                res_status_r;
  slot_t                  res_slot_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  slot_t                  out_slot_r;

  logic [ENT_W-1:0]       mem [TABLE_DEPTH];
  logic [ENT_W-1:0]       rdata_r;

  size_t                  size;
  logic [SIZE_W:0]        trial;
  logic [SIZE_W:0]        trial_sub;
  size_t                  rem_nxt;
  size_t                  addr_inc;
  size_t                  addr_nxt;
  size_t                  probe_inc;
  logic                   last_probe;
  logic                   slot_empty;
  logic                   key_hit;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [ENT_W-1:0]       mem_wd;

  // effective size: zero acts as one, clipped to the memory depth
  always_comb begin
    if (tsize_r == '0) begin
      size = size_t'(1);
    end else if (32'(tsize_r) > TABLE_DEPTH) begin
      size = size_t'(TABLE_DEPTH);
    end else begin
      size = tsize_r;
    end
  end

  // one restoring step of key % size
  assign trial     = {rem_r, div_q_r[KEY_W-1]};
  assign trial_sub = trial - {1'b0, size};
  assign rem_nxt   = (trial >= {1'b0, size}) ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];

  assign addr_inc   = addr_r + size_t'(1);
  assign addr_nxt   = (addr_inc >= size) ? '0 : addr_inc;
  assign probe_inc  = probe_cnt_r + size_t'(1);
  assign last_probe = (probe_inc == size);
  assign slot_empty = !rdata_r[ENT_W-1];
  assign key_hit    = (rdata_r[KEY_W-1:0] == key_r);

  assign mem_we = (state_r == S_CLEAR) ||
                  ((state_r == S_CHK) && (cmd_r == CMD_INSERT) && slot_empty);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : AW'(addr_r);
  assign mem_wd = (state_r == S_CLEAR) ? '0 : {1'b1, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[AW'(addr_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      tsize_r     <= SIZE_RESET;
      entry_cnt_r <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        tsize_r <= cfg_data;
      end
      // in S_RES the result move below refills the output register
      if (out_valid_r && out_ready && (state_r != S_RES)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + AW'(1);
          if (clr_cnt_r == AW'(TABLE_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r     <= in_cmd;
            key_r     <= in_key;
            div_q_r   <= in_key;
            div_cnt_r <= DIV_CNT_W'(KEY_W - 1);
            rem_r     <= '0;
            state_r   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r     <= rem_nxt;
          div_q_r   <= div_q_r << 1;
          div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
          if (div_cnt_r == '0) begin
            addr_r      <= rem_nxt;
            probe_cnt_r <= '0;
            if ((cmd_r == CMD_INSERT) && (entry_cnt_r >= size)) begin
              res_status_r <= ST_FULL;
              res_slot_r   <= '0;
              state_r      <= S_RES;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          priority if (cmd_r == CMD_INSERT && slot_empty) begin
            entry_cnt_r  <= entry_cnt_r + size_t'(1);
            res_status_r <= ST_OK;
            res_slot_r   <= addr_r[SLOT_W-1:0];
            state_r      <= S_RES;
          end else if (cmd_r == CMD_SEARCH && slot_empty) begin
            res_status_r <= ST_MISS;
            res_slot_r   <= '0;
            state_r      <= S_RES;
          end else if (cmd_r == CMD_SEARCH && key_hit) begin
            res_status_r <= ST_OK;
            res_slot_r   <= addr_r[SLOT_W-1:0];
            state_r      <= S_RES;
          end else if (last_probe) begin
            res_status_r <= (cmd_r == CMD_INSERT) ? ST_FULL : ST_MISS;
            res_slot_r   <= '0;
            state_r      <= S_RES;
          end else begin
            addr_r      <= addr_nxt;
            probe_cnt_r <= probe_inc;
            state_r     <= S_RD;
          end
        end
        S_RES: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

`ifndef SYNTHESIS
  // a probe write only ever fills an empty slot for an insert
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (cmd_r == CMD_INSERT && slot_empty))
    else $error("probe write outside an insert into an empty slot");

  // probe address and probe count stay inside the table in use
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_CHK) |-> (addr_r < size && probe_cnt_r < size))
    else $error("probe outside the table");

  // a stored key bumps the entry count by exactly one
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && cmd_r == CMD_INSERT && slot_empty)
      |=> entry_cnt_r == $past(entry_cnt_r) + size_t'(1))
    else $error("entry count not advanced on insert");

  // no item is taken during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ready)
    else $error("item accepted while clearing");

  // failed operations report slot zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK)
      |-> (out_slot == '0 && (out_status == ST_FULL || out_status == ST_MISS)))
    else $error("bad failure result");
`endif

endmodule
